FILE: hdl/bha_pkg.sv
// ----------------------------------------------------------------------------
// bha_pkg
// shared types and constants for the button hold and auto-repeat detector
// ----------------------------------------------------------------------------
package bha_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int BTN_W       = 4;
	localparam int BTN_IDX_W   = 2;
	localparam int DUR_W       = 32;
	localparam int CFG_W       = 16;
	localparam int CNT_W       = 8;
	localparam int CFG_IDX_W   = 1;

	localparam logic [BTN_W-1:0] BTN_MASK =
		(NUM_BUTTONS >= BTN_W) ? {BTN_W{1'b1}} : BTN_W'((1 << NUM_BUTTONS) - 1);

	localparam logic [CFG_IDX_W-1:0] REG_FIRE_RATE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 1'b1;

	localparam logic [CFG_W-1:0] FIRE_RATE_RST   = 16'd200;
	localparam logic [CFG_W-1:0] FIRST_DELAY_RST = 16'd1000;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hdl/bha_div.sv
// ----------------------------------------------------------------------------
// bha_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bha_div
	import bha_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DUR_W-1:0] dividend,
	input  logic [CFG_W-1:0] divisor,
	output logic [DUR_W-1:0] quotient,
	output div_stat_t        stat
);

	localparam int STEP_W = $clog2(DUR_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DUR_W - 1);

	logic [DUR_W-1:0]  dq_q;
	logic [CFG_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CFG_W:0]    trial;
	logic [CFG_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, dq_q[DUR_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DUR_W-2:0], ge};
			rem_q <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = dq_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider not busy after start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && step_q == LAST_STEP) |=> done_q)
		else $error("divider missed done");

endmodule

FILE: hdl/button_hold_autorepeat.sv
// ----------------------------------------------------------------------------
// button_hold_autorepeat
// hold and auto-repeat event detector for a small set of buttons
// ----------------------------------------------------------------------------
// flow: without a division an accepted word passes through the done state to the registered
//   output; otherwise the bit-serial divider runs first, one quotient bit per duration bit
// throughput: one word at a time, next word taken once the result is registered
// reset: repeat count 0, fire rate 200, first delay 1000, output empty
// ----------------------------------------------------------------------------
module button_hold_autorepeat
	import bha_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// watched_button, held_mask, starting_mask, held_duration_ms
	input  logic [47:0]          s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hold_event
	output logic [7:0]           m_tdata,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] fire_rate_q;
	logic [CFG_W-1:0] first_delay_q;
	logic [CNT_W-1:0] repeat_q;
	logic             fire_q;
	logic             out_valid_q;
	logic             out_event_q;

	logic [BTN_IDX_W-1:0] watched;
	logic [BTN_W-1:0]     held;
	logic [BTN_W-1:0]     starting;
	logic [DUR_W-1:0]     duration;
	logic [BTN_W-1:0]     self_bit;
	logic                 eligible;
	logic [DUR_W:0]       diff;
	logic [CFG_W-1:0]     rate_eff;
	logic                 s_accept;
	logic                 div_start;
	logic [DUR_W-1:0]     quot;
	div_stat_t            div_stat;
	logic                 q_reached;
	logic                 out_free;

	assign watched  = s_tdata[1:0];
	assign held     = s_tdata[5:2] & BTN_MASK;
	assign starting = s_tdata[9:6] & BTN_MASK;
	assign duration = s_tdata[41:10];

	assign self_bit = BTN_W'(1) << watched;
	assign eligible = (int'(watched) < NUM_BUTTONS) && ((held & self_bit) != '0)
		&& (((held | starting) & ~self_bit) == '0);
	assign diff     = {1'b0, duration} - {{(DUR_W-CFG_W+1){1'b0}}, first_delay_q};
	assign rate_eff = (fire_rate_q == '0) ? CFG_W'(1) : fire_rate_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign div_start = s_accept && eligible && !diff[DUR_W];
	assign out_free  = !out_valid_q || m_tready;
	assign q_reached = (quot[DUR_W-1:CNT_W] != '0) || (quot[CNT_W-1:0] >= repeat_q);

	bha_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff[DUR_W-1:0]),
		.divisor  (rate_eff),
		.quotient (quot),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_rate_q   <= FIRE_RATE_RST;
			first_delay_q <= FIRST_DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_FIRE_RATE:   fire_rate_q   <= cfg_wdata;
				REG_FIRST_DELAY: first_delay_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			repeat_q    <= '0;
			fire_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_event_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (held == '0)
							repeat_q <= '0;
						fire_q  <= 1'b0;
						state_q <= div_start ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						fire_q <= q_reached;
						if (q_reached)
							repeat_q <= quot[CNT_W-1:0] + 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_event_q <= fire_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_event_q};

	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on idle divider");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q != ST_IDLE)) else $error("accept did not start work");
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not registered");
	a_div_only_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy) else $error("divider restarted while busy");

endmodule
